>>> design/cnms_pkg.sv
// ============================================================================
// cnms_pkg: shared types and constants for canny_nms_double_threshold
// Widths, register indexes, line store entry layout and the angle binning.
// ============================================================================
package cnms_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
    localparam int MAG_BITS    = 16;
    localparam int ANGLE_BITS  = 16;
    localparam int WIDTH_BITS  = 12;
    localparam int HEIGHT_BITS = 16;
    localparam int THR_BITS    = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int WIN_TAPS    = 9;

    // Register reset values
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(2048);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
    localparam logic [THR_BITS-1:0]    LOW_RESET    = THR_BITS'(100);
    localparam logic [THR_BITS-1:0]    HIGH_RESET   = THR_BITS'(200);

    // Smallest legal frame dimension, border included
    localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN  = WIDTH_BITS'(3);
    localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX  = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN = HEIGHT_BITS'(3);

    // pi/8 in the angle format where pi = 2^(ANGLE_BITS-1)
    localparam logic [ANGLE_BITS-2:0] EIGHTH_PI = (ANGLE_BITS-1)'(1 << (ANGLE_BITS - 4));

    typedef logic [MAG_BITS-1:0]  mag_t;
    typedef logic [1:0]           dir_t;
    typedef logic [ADDR_BITS-1:0] addr_t;

    // Direction bins
    localparam dir_t DIR_HORIZ = 2'd0;
    localparam dir_t DIR_DIAG_DOWN_RIGHT = 2'd1;
    localparam dir_t DIR_VERT  = 2'd2;
    localparam dir_t DIR_DIAG_DOWN_LEFT = 2'd3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_LOW_THR      = 2'd2,
        REG_HIGH_THR     = 2'd3
    } cfg_reg_t;

    // One column of the line stores
    typedef struct packed {
        mag_t upper;
        mag_t middle;
        dir_t dir;
    } line_entry_t;

    // Scan position flags of one pixel
    typedef struct packed {
        logic produce;
        logic last_col;
    } scan_info_t;

    // Fold to 0..pi, add pi/8, wrap modulo pi, take the top two bits
    function automatic dir_t quantize_angle(input logic [ANGLE_BITS-1:0] raw);
        logic [ANGLE_BITS-2:0] t;
        t = raw[ANGLE_BITS-2:0] + EIGHTH_PI;
        return t[ANGLE_BITS-2 -: 2];
    endfunction

endpackage

>>> design/canny_nms_double_threshold.sv
// ============================================================================
// canny_nms_double_threshold: Canny suppression and double threshold, 3x3
// Streams raster pixels with magnitude and angle, keeps two magnitude lines
// and one direction line in a single memory, and emits one edge flag per
// interior pixel.
//
//   Channel   Handshake              Beat contents
//   in        in_valid / in_ready    magnitude, angle
//   out       out_valid / out_ready  edge_res, row_end
//   config    wr_en                  wr_index, wr_data
//
// One pixel per clock while no result beat is held; an accepted beat passes
// the memory read register, then window and decision into the output register.
// The line memory is read at accept and written back as the beat leaves the
// read stage; the two accesses always hit different columns.
// A held output beat stalls the whole pipe; in_ready drops only then.
// Reset clears counters, window and pipe valids; line memory is not cleared.
// ============================================================================
module canny_nms_double_threshold
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [cnms_pkg::CFG_INDEX_BITS-1:0]    wr_index,
    input  logic [cnms_pkg::CFG_DATA_BITS-1:0]     wr_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [cnms_pkg::MAG_BITS-1:0]          magnitude,
    input  logic signed [cnms_pkg::ANGLE_BITS-1:0] angle,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   edge_res,
    output logic                                   row_end
);
    import cnms_pkg::*;

    logic        pipe_en;
    logic        in_fire;
    addr_t       col;
    scan_info_t  info;
    logic [THR_BITS-1:0] low_thr, high_thr;

    logic        s1_valid_reg;
    mag_t        s1_mag_reg;
    dir_t        s1_dir_reg;
    addr_t       s1_addr_reg;
    scan_info_t  s1_info_reg;

    line_entry_t rd_entry;
    line_entry_t wb_entry;
    logic        s1_adv;
    logic        edge_next;

    logic        out_valid_reg;
    logic        edge_reg;
    logic        row_end_reg;

    // Advance the pipe unless a result beat is held
    assign pipe_en  = !out_valid_reg || out_ready;
    assign in_ready = pipe_en;
    assign in_fire  = in_valid && in_ready;
    assign s1_adv   = s1_valid_reg && pipe_en;

    cnms_scan_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .advance  (in_fire),
        .col      (col),
        .info     (info),
        .low_thr  (low_thr),
        .high_thr (high_thr)
    );

    // Capture the accepted beat alongside the memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mag_reg  <= magnitude;
            s1_dir_reg  <= quantize_angle(angle);
            s1_addr_reg <= col;
            s1_info_reg <= info;
        end
    end

    // Roll the column up one line and store the new pixel
    assign wb_entry.upper  = rd_entry.middle;
    assign wb_entry.middle = s1_mag_reg;
    assign wb_entry.dir    = s1_dir_reg;

    cnms_line_mem u_mem
    (
        .clk         (clk),
        .rd_en       (in_fire),
        .rd_addr     (col),
        .rd_data     (rd_entry),
        .mem_wr_en   (s1_adv),
        .mem_wr_addr (s1_addr_reg),
        .mem_wr_data (wb_entry)
    );

    cnms_window_eval u_win
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (s1_adv),
        .col_entry (rd_entry),
        .new_mag   (s1_mag_reg),
        .low_thr   (low_thr),
        .high_thr  (high_thr),
        .edge_next (edge_next)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= s1_valid_reg && s1_info_reg.produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            edge_reg    <= edge_next;
            row_end_reg <= s1_info_reg.last_col;
        end
    end

    assign out_valid = out_valid_reg;
    assign edge_res  = edge_reg;
    assign row_end   = row_end_reg;

    // An accepted beat always occupies the read stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted beat lost before the read stage");

    // A stalled read stage keeps its beat and its column
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !pipe_en |=> s1_valid_reg && $stable(s1_addr_reg)
            && $stable(s1_mag_reg))
        else $error("read stage changed while stalled");

    // No input is taken while a result beat is held
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !in_fire)
        else $error("beat accepted while the output is blocked");

endmodule

>>> design/cnms_line_mem.sv
// ============================================================================
// cnms_line_mem: line store memory
// Single write port, single registered read port holding two magnitude lines
// and the direction line, one entry per column.
// ============================================================================
module cnms_line_mem
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  cnms_pkg::addr_t      rd_addr,
    output cnms_pkg::line_entry_t rd_data,
    input  logic                 mem_wr_en,
    input  cnms_pkg::addr_t      mem_wr_addr,
    input  cnms_pkg::line_entry_t mem_wr_data
);
    import cnms_pkg::*;

    line_entry_t mem [MAX_WIDTH];
    line_entry_t rd_data_reg;

    // Write back the updated column
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    // Read on request only, hold the data otherwise
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

    // A read never targets the column being written in the same cycle
    assert property (@(posedge clk) rd_en && mem_wr_en |-> rd_addr != mem_wr_addr)
        else $error("line store read and write collide on one column");

endmodule

>>> design/cnms_scan_ctrl.sv
// ============================================================================
// cnms_scan_ctrl: configuration registers and raster position
// Holds the four registers and the column and row counters, and flags each
// accepted pixel with whether it yields a result and whether it ends a row.
// ============================================================================
module cnms_scan_ctrl
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [cnms_pkg::CFG_INDEX_BITS-1:0]    wr_index,
    input  logic [cnms_pkg::CFG_DATA_BITS-1:0]     wr_data,
    input  logic                                   advance,
    output cnms_pkg::addr_t                        col,
    output cnms_pkg::scan_info_t                   info,
    output logic [cnms_pkg::THR_BITS-1:0]          low_thr,
    output logic [cnms_pkg::THR_BITS-1:0]          high_thr
);
    import cnms_pkg::*;

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [THR_BITS-1:0]    low_reg;
    logic [THR_BITS-1:0]    high_reg;
    addr_t                  col_reg, col_next;
    logic [HEIGHT_BITS-1:0] row_reg, row_next;
    logic [WIDTH_BITS-1:0]  width_eff;
    logic [WIDTH_BITS-1:0]  col_last;
    logic [HEIGHT_BITS-1:0] row_last;
    logic                   last_col;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            low_reg    <= LOW_RESET;
            high_reg   <= HIGH_RESET;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_IMAGE_WIDTH:  width_reg  <= wr_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= wr_data[HEIGHT_BITS-1:0];
                REG_LOW_THR:      low_reg    <= wr_data[THR_BITS-1:0];
                REG_HIGH_THR:     high_reg   <= wr_data[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the frame size to its legal range
    always_comb
    begin
        priority if (width_reg < WIDTH_MIN)
            width_eff = WIDTH_MIN;
        else if (width_reg > WIDTH_MAX)
            width_eff = WIDTH_MAX;
        else
            width_eff = width_reg;
        col_last = width_eff - WIDTH_BITS'(1);
        if (height_reg < HEIGHT_MIN)
            row_last = HEIGHT_MIN - HEIGHT_BITS'(1);
        else
            row_last = height_reg - HEIGHT_BITS'(1);
    end

    assign last_col = ({1'b0, col_reg} >= col_last);

    // Advance the raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = (row_reg >= row_last) ? '0 : row_reg + HEIGHT_BITS'(1);
        end
        else
        begin
            col_next = col_reg + ADDR_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col           = col_reg;
    assign info.produce  = (col_reg >= ADDR_BITS'(2)) && (row_reg >= HEIGHT_BITS'(2));
    assign info.last_col = last_col;
    assign low_thr       = low_reg;
    assign high_thr      = high_reg;

    // A row end always sends the column back to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_col |=> col_reg == '0)
        else $error("column counter did not wrap at row end");

    // Between two pixels the column either steps by one or restarts
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last_col |=> col_reg == $past(col_reg) + ADDR_BITS'(1))
        else $error("column counter skipped");

    // The row count only moves at a row end
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last_col |=> $stable(row_reg))
        else $error("row counter moved inside a row");

endmodule

>>> design/cnms_window_eval.sv
// ============================================================================
// cnms_window_eval: 3x3 window and edge decision
// Shifts the line store column into the window, then applies non-maximum
// suppression along the binned direction and the double threshold.
// ============================================================================
module cnms_window_eval
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  cnms_pkg::line_entry_t         col_entry,
    input  cnms_pkg::mag_t                new_mag,
    input  logic [cnms_pkg::THR_BITS-1:0] low_thr,
    input  logic [cnms_pkg::THR_BITS-1:0] high_thr,
    output logic                          edge_next
);
    import cnms_pkg::*;

    // Taps indexed row*3+col, row 0 top, col 0 oldest
    mag_t win_reg  [WIN_TAPS];
    mag_t win_next [WIN_TAPS];
    dir_t cdir_reg [2];
    dir_t bin;
    mag_t cen, fwd, bwd;
    logic kept, strong_near;

    // Shift window left and load the new column
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3 + 0] = win_reg[k*3 + 1];
            win_next[k*3 + 1] = win_reg[k*3 + 2];
        end
        win_next[2] = col_entry.upper;
        win_next[5] = col_entry.middle;
        win_next[8] = new_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
            cdir_reg[0] <= '0;
            cdir_reg[1] <= '0;
        end
        else if (shift_en)
        begin
            for (int k = 0; k < WIN_TAPS; k++)
            begin
                win_reg[k] <= win_next[k];
            end
            cdir_reg[0] <= cdir_reg[1];
            cdir_reg[1] <= col_entry.dir;
        end
    end

    // Pick forward and backward neighbors of the center
    assign bin = cdir_reg[1];
    assign cen = win_next[4];

    always_comb
    begin
        unique case (bin)
            DIR_HORIZ:
            begin
                fwd = win_next[5];
                bwd = win_next[3];
            end
            DIR_DIAG_DOWN_RIGHT:
            begin
                fwd = win_next[8];
                bwd = win_next[0];
            end
            DIR_VERT:
            begin
                fwd = win_next[7];
                bwd = win_next[1];
            end
            default:
            begin
                fwd = win_next[6];
                bwd = win_next[2];
            end
        endcase
    end

    // Check neighbors against the strong threshold
    always_comb
    begin
        strong_near = 1'b0;
        for (int k = 0; k < WIN_TAPS; k++)
        begin
            if (k != 4 && win_next[k] > high_thr)
            begin
                strong_near = 1'b1;
            end
        end
    end

    assign kept      = (cen >= fwd) && (cen > bwd);
    assign edge_next = kept && ((cen > high_thr) || ((cen > low_thr) && strong_near));

endmodule

>>> verif/canny_nms_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Edge flag checker for canny_nms_double_threshold
// Watches the config port and both channels, keeps its own copy of the line
// stores, 3x3 window and scan position, predicts the edge flag and row end
// of every interior pixel, and compares each result beat against the
// oldest prediction.
// ============================================================================
module canny_nms_checker
    import cnms_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [CFG_INDEX_BITS-1:0]       wr_index,
    input  logic [CFG_DATA_BITS-1:0]        wr_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [MAG_BITS-1:0]             magnitude,
    input  logic signed [ANGLE_BITS-1:0]    angle,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            edge_res,
    input  logic                            row_end,
    output int                              mismatch_count,
    output int                              flags_waiting,
    output logic [ADDR_BITS-1:0]            next_col,
    output logic [HEIGHT_BITS-1:0]          next_row
);

    typedef struct packed {
        logic edge_flag;
        logic row_last;
    } edge_result_t;

    // Register copies
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [THR_BITS-1:0]    weak_thr;
    logic [THR_BITS-1:0]    strong_thr;

    // Line stores, window and scan position
    mag_t                   upper_mag [MAX_WIDTH];
    mag_t                   middle_mag [MAX_WIDTH];
    dir_t                   dir_line [MAX_WIDTH];
    mag_t                   win [WIN_TAPS];
    dir_t                   center_dirs [2];
    logic [ADDR_BITS-1:0]   scan_col;
    logic [HEIGHT_BITS-1:0] scan_row;

    edge_result_t           expected_flags [$];
    edge_result_t           oldest;
    int                     error_total;

    // Advance the scan by one pixel and queue the flag it produces, if any
    task automatic predict_pixel(input mag_t m, input logic [ANGLE_BITS-1:0] a);
        int                     eff_w;
        int                     eff_h;
        logic                   last_col;
        mag_t                   up;
        mag_t                   mid;
        mag_t                   cen;
        mag_t                   fwd;
        mag_t                   bwd;
        logic [ANGLE_BITS-2:0]  folded;
        logic                   kept;
        logic                   strong_near;
        edge_result_t           res;

        eff_w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        eff_h = (height_reg < 3) ? 3 : int'(height_reg);
        last_col = (int'(scan_col) >= eff_w - 1);

        // Rotate the magnitude lines and shift the window left
        up = upper_mag[scan_col];
        mid = middle_mag[scan_col];
        upper_mag[scan_col] = mid;
        middle_mag[scan_col] = m;
        for (int k = 0; k < 3; k++) begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = m;

        // Fold to half a turn, offset by pi/8, keep the top two bits
        folded = a[ANGLE_BITS-2:0] + EIGHTH_PI;
        center_dirs[0] = center_dirs[1];
        center_dirs[1] = dir_line[scan_col];
        dir_line[scan_col] = folded[ANGLE_BITS-2 -: 2];

        if (scan_col >= 2 && scan_row >= 2) begin
            cen = win[4];
            case (center_dirs[0])
                DIR_HORIZ:
                begin
                    fwd = win[5];
                    bwd = win[3];
                end
                DIR_DIAG_DOWN_RIGHT:
                begin
                    fwd = win[8];
                    bwd = win[0];
                end
                DIR_VERT:
                begin
                    fwd = win[7];
                    bwd = win[1];
                end
                DIR_DIAG_DOWN_LEFT:
                begin
                    fwd = win[6];
                    bwd = win[2];
                end
            endcase
            kept = (cen >= fwd) && (cen > bwd);
            strong_near = 1'b0;
            for (int k = 0; k < WIN_TAPS; k++) begin
                if (k != 4 && win[k] > strong_thr)
                    strong_near = 1'b1;
            end
            res.edge_flag = kept && ((cen > strong_thr) || (cen > weak_thr && strong_near));
            res.row_last = last_col;
            expected_flags.push_back(res);
        end

        // Wrap at the end of a row, and at the end of the frame
        if (last_col) begin
            scan_col = '0;
            scan_row = (int'(scan_row) >= eff_h - 1) ? '0 : scan_row + 1'b1;
        end
        else begin
            scan_col = scan_col + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            weak_thr = LOW_RESET;
            strong_thr = HIGH_RESET;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                upper_mag[i] = '0;
                middle_mag[i] = '0;
                dir_line[i] = DIR_HORIZ;
            end
            for (int i = 0; i < WIN_TAPS; i++)
                win[i] = '0;
            center_dirs[0] = DIR_HORIZ;
            center_dirs[1] = DIR_HORIZ;
            scan_col = '0;
            scan_row = '0;
            error_total = 0;
            expected_flags.delete();
            mismatch_count <= 0;
            flags_waiting <= 0;
            next_col <= '0;
            next_row <= '0;
        end
        else begin
            // Compare a result beat against the oldest prediction
            if (out_valid && out_ready) begin
                if (expected_flags.size() == 0) begin
                    $display("%0t: result beat expected none, actual edge_res %0b row_end %0b",
                             $time, edge_res, row_end);
                    error_total++;
                end
                else begin
                    oldest = expected_flags.pop_front();
                    if (edge_res !== oldest.edge_flag) begin
                        $display("%0t: edge_res expected %0b, actual %0b",
                                 $time, oldest.edge_flag, edge_res);
                        error_total++;
                    end
                    if (row_end !== oldest.row_last) begin
                        $display("%0t: row_end expected %0b, actual %0b",
                                 $time, oldest.row_last, row_end);
                        error_total++;
                    end
                end
            end

            // Track register writes
            if (wr_en) begin
                case (cfg_reg_t'(wr_index))
                    REG_IMAGE_WIDTH:  width_reg = wr_data[WIDTH_BITS-1:0];
                    REG_IMAGE_HEIGHT: height_reg = wr_data[HEIGHT_BITS-1:0];
                    REG_LOW_THR:      weak_thr = wr_data[THR_BITS-1:0];
                    REG_HIGH_THR:     strong_thr = wr_data[THR_BITS-1:0];
                endcase
            end

            if (in_valid && in_ready)
                predict_pixel(magnitude, angle);

            mismatch_count <= error_total;
            flags_waiting <= expected_flags.size();
            next_col <= scan_col;
            next_row <= scan_row;
        end
    end

endmodule

>>> verif/canny_nms_double_threshold_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Testbench for canny_nms_double_threshold
// Drives raster pixels through the block under several frame sizes and
// threshold settings, with random gaps and stalls on both channels, and
// leaves prediction and comparison to the checker beside the block.
// ============================================================================
module canny_nms_double_threshold_test;
    import cnms_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int WIDE_PIXELS   = 300;
    localparam int RANDOM_PIXELS = 1450;

    // 5x5 directed frame: threshold edges, equal neighbors, every direction bin
    localparam logic [MAG_BITS-1:0] DIRECTED_MAG [25] = '{
        16'd0,   16'd65535, 16'd150, 16'd150, 16'd0,
        16'd150, 16'd201,   16'd200, 16'd150, 16'd65535,
        16'd101, 16'd150,   16'd300, 16'd300, 16'd100,
        16'd0,   16'd250,   16'd101, 16'd99,  16'd65535,
        16'd200, 16'd200,   16'd200, 16'd101, 16'd0
    };
    localparam logic [ANGLE_BITS-1:0] DIRECTED_ANGLE [25] = '{
        16'h0000, 16'h8000, 16'h7FFF, 16'hC000, 16'hFFFF,
        16'h4000, 16'h0000, 16'h1000, 16'h3000, 16'h2000,
        16'hA000, 16'h5000, 16'h7000, 16'h8000, 16'h6000,
        16'h1234, 16'h7FFF, 16'h0FFF, 16'h2FFF, 16'hF000,
        16'hFFFF, 16'hEDCB, 16'h0001, 16'h8001, 16'h4000
    };

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          wr_en;
    logic [CFG_INDEX_BITS-1:0]     wr_index;
    logic [CFG_DATA_BITS-1:0]      wr_data;
    logic                          in_valid;
    logic                          in_ready;
    logic [MAG_BITS-1:0]           magnitude;
    logic signed [ANGLE_BITS-1:0]  angle;
    logic                          out_valid;
    logic                          out_ready;
    logic                          edge_res;
    logic                          row_end;

    int                            mismatch_count;
    int                            flags_waiting;
    logic [ADDR_BITS-1:0]          next_col;
    logic [HEIGHT_BITS-1:0]        next_row;

    logic                          steady;
    logic                          hold_req;
    logic [WIDTH_BITS-1:0]         cur_width;
    logic [THR_BITS-1:0]           low_thr_now;
    logic [THR_BITS-1:0]           high_thr_now;
    int                            idle_cycles = 0;
    // Columns below this count have been written often enough to read back
    int                            primed_width = 0;

    canny_nms_double_threshold DUT (.*);

    canny_nms_checker flag_check (.*);

    always #5 clk = ~clk;

    function automatic int clamp_width(input logic [WIDTH_BITS-1:0] raw);
        return (raw < 3) ? 3 : (raw > MAX_WIDTH) ? MAX_WIDTH : int'(raw);
    endfunction

    // Mostly near the thresholds, so that weak, strong and suppressed all occur
    function automatic mag_t pick_mag();
        int base;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return mag_t'($urandom);
            4, 5, 6: base = int'(high_thr_now) - 40 + int'($urandom_range(0, 80));
            7, 8:    base = int'(low_thr_now) - 40 + int'($urandom_range(0, 80));
            default: base = int'($urandom_range(0, 255));
        endcase
        if (base < 0)
            base = 0;
        if (base > 65535)
            base = 65535;
        return mag_t'(base);
    endfunction

    // Mostly random, some on the bin boundaries and the ends of the range
    function automatic logic [ANGLE_BITS-1:0] pick_angle();
        case ($urandom_range(0, 7))
            6:
            begin
                case ($urandom_range(0, 7))
                    0:       return 16'h0FFF;
                    1:       return 16'h1000;
                    2:       return 16'h2FFF;
                    3:       return 16'h3000;
                    4:       return 16'h4FFF;
                    5:       return 16'h5000;
                    6:       return 16'h6FFF;
                    default: return 16'h7000;
                endcase
            end
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            default: return ANGLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [THR_BITS-1:0] pick_thr();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return THR_BITS'($urandom);
            default: return THR_BITS'($urandom_range(0, 1000));
        endcase
    endfunction

    // Offer one pixel beat, with random gaps ahead of it, and hold until taken
    task automatic push_pixel(input mag_t m, input logic [ANGLE_BITS-1:0] a);
        while (!steady && $urandom_range(0, 99) < 19) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        magnitude <= m;
        angle <= a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drain: stop offering, wait for every flag, then let the pipe empty
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (flags_waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; a width change goes in only where every line entry
    // that it brings into use is already written
    task automatic set_register(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
        logic allowed;
        allowed = 1'b1;
        case (idx)
            REG_IMAGE_WIDTH:
            begin
                allowed = (next_col == 0 && next_row == 0) ||
                          (clamp_width(value[WIDTH_BITS-1:0]) <= clamp_width(cur_width) &&
                           (next_row >= 2 ||
                            clamp_width(value[WIDTH_BITS-1:0]) <= primed_width));
                if (allowed)
                    cur_width = value[WIDTH_BITS-1:0];
            end
            REG_LOW_THR:  low_thr_now = value[THR_BITS-1:0];
            REG_HIGH_THR: high_thr_now = value[THR_BITS-1:0];
            default: ;
        endcase
        if (allowed) begin
            wr_en <= 1'b1;
            wr_index <= idx;
            wr_data <= value;
            @(posedge clk);
            wr_en <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Result side: random back-pressure, plus one long hold on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 19);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int                    sent;
        int                    batch;
        logic                  hold_done;
        logic [WIDTH_BITS-1:0] raw_w;
        logic [HEIGHT_BITS-1:0] raw_h;

        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_IMAGE_WIDTH;
        wr_data = '0;
        in_valid = 1'b0;
        magnitude = '0;
        angle = '0;
        steady = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        cur_width = WIDTH_RESET;
        low_thr_now = LOW_RESET;
        high_thr_now = HIGH_RESET;
        sent = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed 5x5 frame
        set_register(REG_IMAGE_WIDTH, 16'd5);
        set_register(REG_IMAGE_HEIGHT, 16'd5);
        set_register(REG_LOW_THR, 16'd100);
        set_register(REG_HIGH_THR, 16'd200);
        for (int k = 0; k < 25; k++)
            push_pixel(DIRECTED_MAG[k], DIRECTED_ANGLE[k]);

        // Width above range clamps to the widest row; tallest height
        quiesce();
        primed_width = 5;
        set_register(REG_IMAGE_WIDTH, 16'hFFFF);
        set_register(REG_IMAGE_HEIGHT, 16'hFFFF);
        for (int k = 0; k < WIDE_PIXELS; k++)
            push_pixel(pick_mag(), pick_angle());

        // Shrink both mid-row onto columns that are already written
        quiesce();
        set_register(REG_IMAGE_HEIGHT, 16'd4);
        set_register(REG_IMAGE_WIDTH, 16'd5);
        for (int k = 0; k < 30; k++)
            push_pixel(pick_mag(), pick_angle());

        // Random batches with random settings between them
        while (sent < RANDOM_PIXELS) begin
            quiesce();
            if ($urandom_range(0, 3) == 0) begin
                raw_w = ($urandom_range(0, 7) == 0) ? WIDTH_BITS'($urandom_range(0, 2))
                                                    : WIDTH_BITS'($urandom_range(3, 12));
                set_register(REG_IMAGE_WIDTH, {4'($urandom), raw_w});
            end
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 7))
                    0:       raw_h = HEIGHT_BITS'($urandom_range(0, 2));
                    1:       raw_h = '1;
                    default: raw_h = HEIGHT_BITS'($urandom_range(3, 8));
                endcase
                set_register(REG_IMAGE_HEIGHT, raw_h);
            end
            if ($urandom_range(0, 2) == 0)
                set_register(REG_LOW_THR, pick_thr());
            if ($urandom_range(0, 2) == 0)
                set_register(REG_HIGH_THR, pick_thr());

            batch = $urandom_range(1, 60);

            // Fill the block behind a long result hold, once
            if (!hold_done && sent >= 600) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
                batch = 60;
            end
            steady = (sent >= 900 && sent < 1300);

            repeat (batch) push_pixel(pick_mag(), pick_angle());
            sent += batch;
        end

        quiesce();
        if (mismatch_count == 0 && flags_waiting == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
